FILE: hdl/tbsa_pkg.sv
// Package of shared types and constants for the tree bitmap slot allocator.
package tbsa_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 11;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot_in;
    } t_cmd;

    typedef struct packed {
        logic               status;
        logic [SLOT_W-1:0]  slot_out;
        logic [COUNT_W-1:0] used_count;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_DESC,
        ST_UP,
        ST_FREE
    } t_state;

endpackage

FILE: hdl/tbsa_pair_ram.sv
// Single-port-write, registered-read memory holding sibling pairs of tree bits.
module tbsa_pair_ram
    import tbsa_pkg::*;
#(
    parameter int ADDR_W = $clog2(SLOTS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [1:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [1:0]        o_rdata
);

    logic [1:0] r_mem [2**ADDR_W];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tree_bitmap_slot_allocator_top.sv
// Top level of the tree bitmap slot allocator: control sequencer around the pair memory.
//
//   channel  ports                       direction  handshake
//   command  start, i_cmd (t_cmd)        in         taken when start & !busy
//   result   o_done, o_result (t_result) out        one-cycle strobe, no back-pressure
//
// Tree node n lives in memory word n/2, bit n%2, so one read returns both children.
// Allocate descends from the root to a free leaf, then marks nodes on the way back up,
// one memory read-modify-write per level.
// Free clears one bit per level, from the leaf up to the root.
// After reset the memory is swept to zero, one word a cycle, with busy high.
// The result word shows on the cycle after the last memory step; it cannot be stalled.
module tree_bitmap_slot_allocator_top
    import tbsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int PW = $clog2(SLOTS);
    localparam int NW = PW + 1;
    localparam int UW = $clog2(SLOTS + 1);

    t_state          r_state, n_state;
    logic [NW-1:0]   r_cur, n_cur;
    logic [PW-1:0]   r_slot, n_slot;
    logic [PW-1:0]   r_clr, n_clr;
    logic [UW-1:0]   r_used, n_used;
    logic            r_first, n_first;
    logic            r_was_full, n_was_full;
    logic            r_done, n_done;
    t_result         r_res, n_res;

    logic            mem_we;
    logic [PW-1:0]   mem_waddr;
    logic [1:0]      mem_wdata;
    logic [PW-1:0]   mem_raddr;
    logic [1:0]      mem_rdata;

    logic [NW-1:0]   next_node;
    logic [1:0]      bit_mask;
    logic            leaf_full;

    tbsa_pair_ram #(
        .ADDR_W (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_used     <= '0;
            r_done     <= 1'b0;
            r_first    <= 1'b0;
            r_was_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_used     <= n_used;
            r_done     <= n_done;
            r_first    <= n_first;
            r_was_full <= n_was_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_slot <= n_slot;
        r_res  <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_slot     = r_slot;
        n_clr      = r_clr;
        n_used     = r_used;
        n_first    = r_first;
        n_was_full = r_was_full;
        n_done     = 1'b0;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_cur[NW-1:1];
        mem_wdata  = 2'b00;
        mem_raddr  = '0;

        // Child choice: go right only when the left child is full and the right is free.
        next_node = {r_cur[PW-1:0], mem_rdata[0] & ~mem_rdata[1]};
        bit_mask  = r_cur[0] ? 2'b10 : 2'b01;
        leaf_full = r_first ? ((mem_rdata & bit_mask) != 2'b00) : r_was_full;

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 2'b00;
                n_clr     = r_clr + 1'b1;
                if (r_clr == PW'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_cmd.op == OP_ALLOC) begin
                        mem_raddr = '0;
                        n_state   = ST_ROOT;
                    end else if (32'(i_cmd.slot_in) >= 32'(SLOTS)) begin
                        n_done              = 1'b1;
                        n_res.status        = STAT_FAIL;
                        n_res.slot_out      = i_cmd.slot_in;
                        n_res.used_count    = COUNT_W'(r_used);
                    end else begin
                        n_cur     = {1'b1, PW'(i_cmd.slot_in)};
                        n_slot    = PW'(i_cmd.slot_in);
                        mem_raddr = PW'({1'b1, PW'(i_cmd.slot_in)} >> 1);
                        n_first   = 1'b1;
                        n_state   = ST_FREE;
                    end
                end
            end
            ST_ROOT: begin
                if (mem_rdata[1]) begin
                    n_done           = 1'b1;
                    n_res.status     = STAT_FAIL;
                    n_res.slot_out   = '0;
                    n_res.used_count = COUNT_W'(r_used);
                    n_state          = ST_IDLE;
                end else begin
                    n_cur     = NW'(1);
                    mem_raddr = PW'(1);
                    n_state   = ST_DESC;
                end
            end
            ST_DESC: begin
                n_cur = next_node;
                if (next_node[NW-1]) begin
                    n_slot    = next_node[PW-1:0];
                    mem_raddr = next_node[NW-1:1];
                    n_state   = ST_UP;
                end else begin
                    mem_raddr = next_node[PW-1:0];
                end
            end
            ST_UP: begin
                // Mark this node; climb while the freshly written pair is full.
                mem_we    = 1'b1;
                mem_wdata = mem_rdata | bit_mask;
                mem_raddr = PW'(r_cur >> 2);
                if ((r_cur != NW'(1)) && (mem_wdata == 2'b11)) begin
                    n_cur = r_cur >> 1;
                end else begin
                    n_used           = r_used + 1'b1;
                    n_done           = 1'b1;
                    n_res.status     = STAT_OK;
                    n_res.slot_out   = SLOT_W'(r_slot);
                    n_res.used_count = COUNT_W'(r_used + 1'b1);
                    n_state          = ST_IDLE;
                end
            end
            ST_FREE: begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata & ~bit_mask;
                mem_raddr  = PW'(r_cur >> 2);
                n_first    = 1'b0;
                n_was_full = leaf_full;
                if (r_cur == NW'(1)) begin
                    if (leaf_full && (r_used != '0)) begin
                        n_used = r_used - 1'b1;
                    end
                    n_done           = 1'b1;
                    n_res.status     = STAT_OK;
                    n_res.slot_out   = SLOT_W'(r_slot);
                    n_res.used_count = COUNT_W'(n_used);
                    n_state          = ST_IDLE;
                end else begin
                    n_cur = r_cur >> 1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
